### hw/rtl/enig_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and substitution tables of the two-rotor rotor cipher.
// Used by enig_rotor_ctrl, enig_scramble and two_rotor_enigma_cipher; depends on nothing.
package enig_pkg;

	localparam int LETTER_W = 5;
	localparam logic [LETTER_W:0] LETTERS = 6'd26;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 5;
	localparam int TDATA_W = 8;

	typedef logic [LETTER_W-1:0] letter_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FAST_START   = 2'd0,
		CFG_MIDDLE_START = 2'd1,
		CFG_NOTCH        = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		letter_t fast;
		letter_t mid;
	} pos_t;

	localparam letter_t PLUG_TAB [26] = '{
		5'd2, 5'd1, 5'd0, 5'd4, 5'd3, 5'd5, 5'd7, 5'd6, 5'd8, 5'd9, 5'd24, 5'd11, 5'd20,
		5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd12, 5'd21, 5'd22, 5'd23,
		5'd10, 5'd25};
	localparam letter_t FAST_FWD [26] = '{
		5'd0, 5'd18, 5'd24, 5'd10, 5'd12, 5'd20, 5'd8, 5'd6, 5'd14, 5'd2, 5'd11, 5'd15,
		5'd22, 5'd3, 5'd25, 5'd7, 5'd17, 5'd13, 5'd1, 5'd5, 5'd23, 5'd9, 5'd16, 5'd21,
		5'd19, 5'd4};
	localparam letter_t FAST_INV [26] = '{
		5'd0, 5'd18, 5'd9, 5'd13, 5'd25, 5'd19, 5'd7, 5'd15, 5'd6, 5'd21, 5'd3, 5'd10,
		5'd4, 5'd17, 5'd8, 5'd11, 5'd22, 5'd16, 5'd1, 5'd24, 5'd5, 5'd23, 5'd12, 5'd20,
		5'd2, 5'd14};
	localparam letter_t MID_FWD [26] = '{
		5'd0, 5'd10, 5'd4, 5'd2, 5'd8, 5'd1, 5'd18, 5'd20, 5'd22, 5'd19, 5'd13, 5'd6,
		5'd17, 5'd5, 5'd9, 5'd3, 5'd24, 5'd14, 5'd12, 5'd25, 5'd21, 5'd11, 5'd7, 5'd16,
		5'd15, 5'd23};
	localparam letter_t MID_INV [26] = '{
		5'd0, 5'd5, 5'd3, 5'd15, 5'd2, 5'd13, 5'd11, 5'd22, 5'd4, 5'd14, 5'd1, 5'd21,
		5'd18, 5'd10, 5'd17, 5'd24, 5'd23, 5'd12, 5'd6, 5'd9, 5'd7, 5'd20, 5'd8, 5'd25,
		5'd16, 5'd19};
	localparam letter_t REFLECT_TAB [26] = '{
		5'd10, 5'd20, 5'd14, 5'd8, 5'd25, 5'd15, 5'd16, 5'd21, 5'd3, 5'd18, 5'd0, 5'd23,
		5'd13, 5'd12, 5'd2, 5'd5, 5'd6, 5'd19, 5'd9, 5'd17, 5'd1, 5'd7, 5'd24, 5'd11,
		5'd22, 5'd4};

	// sum of two letters, both below 26, reduced mod 26
	function automatic letter_t add_mod(input letter_t a, input letter_t b);
		logic [LETTER_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= LETTERS) ? letter_t'(s - LETTERS) : s[LETTER_W-1:0];
	endfunction

	// reduce a 5-bit value mod 26
	function automatic letter_t wrap(input letter_t v);
		return ({1'b0, v} >= LETTERS) ? letter_t'({1'b0, v} - LETTERS) : v;
	endfunction

	function automatic letter_t step_down(input letter_t p);
		return (p == '0) ? letter_t'(LETTERS - 6'd1) : letter_t'(p - 5'd1);
	endfunction

endpackage

### hw/rtl/two_rotor_enigma_cipher.sv
`timescale 1ns / 1ps
// Top level of the two-rotor rotor cipher: input stage, letter path, result register.
// Depends on enig_pkg, enig_rotor_ctrl and enig_scramble.
//
// One letter enters per clock cycle unless m_tready stalls the output: the
// letter and the rotor positions it uses are captured in an input stage, and the
// combinational table path feeds the result register. The rotor positions step
// when a letter is taken, so back-to-back letters see the stepped rotors. Letters
// of 26 or more return bad_input with cipher letter zero and leave the rotors
// alone. Writes to fast_start or middle_start reload the position mod 26; the user
// must write configuration only while no letter is in flight; the block does not enforce it.
module two_rotor_enigma_cipher (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [enig_pkg::TDATA_W-1:0]      s_tdata,   // [4:0] letter
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [enig_pkg::TDATA_W-1:0]      m_tdata,   // [4:0] cipher_letter
	output logic [0:0]                        m_tuser,   // [0] bad_input
	input  logic                              cfg_we,
	input  logic [enig_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [enig_pkg::CFG_DATA_W-1:0]   cfg_data
);

	enig_pkg::letter_t letter_in;
	logic              bad_in;
	logic              accept;
	logic              load_out;
	enig_pkg::pos_t    pos_cur;
	enig_pkg::pos_t    pos_use;

	logic              valid_s1;
	enig_pkg::letter_t letter_s1;
	logic              bad_s1;
	enig_pkg::pos_t    pos_s1;
	enig_pkg::letter_t cipher_s1;

	logic              out_valid_q;
	enig_pkg::letter_t cipher_q;
	logic              bad_q;

	assign letter_in = s_tdata[enig_pkg::LETTER_W-1:0];
	assign bad_in    = ({1'b0, letter_in} >= enig_pkg::LETTERS);
	assign load_out  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || load_out;
	assign accept    = s_tvalid && s_tready;

	enig_rotor_ctrl u_rotor_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (accept && !bad_in),
		.pos_cur   (pos_cur),
		.pos_use   (pos_use)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			letter_s1 <= letter_in;
			bad_s1    <= bad_in;
			pos_s1    <= pos_use;
		end
	end

	enig_scramble u_scramble (
		.letter        (letter_s1),
		.bad           (bad_s1),
		.pos           (pos_s1),
		.cipher_letter (cipher_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			cipher_q <= cipher_s1;
			bad_q    <= bad_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(enig_pkg::TDATA_W - enig_pkg::LETTER_W){1'b0}}, cipher_q};
	assign m_tuser  = bad_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, pos_cur.fast} < enig_pkg::LETTERS) && ({1'b0, pos_cur.mid} < enig_pkg::LETTERS))
		else $error("rotor position out of range");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
		else $error("rejected letter carries a nonzero cipher letter");

	a_fast_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !bad_in && !cfg_we) |=>
			(pos_cur.fast == enig_pkg::step_down($past(pos_cur.fast))))
		else $error("fast rotor did not step after a letter");

	a_bad_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && bad_in && !cfg_we) |=> $stable(pos_cur))
		else $error("rejected letter moved a rotor");

endmodule

### hw/rtl/enig_rotor_ctrl.sv
`timescale 1ns / 1ps
// Rotor position and notch registers, configuration writes and stepping.
// Depends on enig_pkg.
module enig_rotor_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [enig_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [enig_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              step,
	output enig_pkg::pos_t                    pos_cur,
	output enig_pkg::pos_t                    pos_use
);

	enig_pkg::letter_t fast_q;
	enig_pkg::letter_t mid_q;
	enig_pkg::letter_t notch_q;

	always_comb begin
		pos_cur.fast = fast_q;
		pos_cur.mid  = mid_q;
		pos_use.fast = fast_q;
		pos_use.mid  = (fast_q == notch_q) ? enig_pkg::step_down(mid_q) : mid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q  <= '0;
			mid_q   <= '0;
			notch_q <= '0;
		end else if (cfg_we) begin
			case (enig_pkg::cfg_idx_t'(cfg_index))
				enig_pkg::CFG_FAST_START:   fast_q  <= enig_pkg::wrap(cfg_data);
				enig_pkg::CFG_MIDDLE_START: mid_q   <= enig_pkg::wrap(cfg_data);
				enig_pkg::CFG_NOTCH:        notch_q <= cfg_data;
				default: begin
				end
			endcase
		end else if (step) begin
			fast_q <= enig_pkg::step_down(fast_q);
			mid_q  <= pos_use.mid;
		end
	end

endmodule

### hw/rtl/enig_scramble.sv
`timescale 1ns / 1ps
// Letter path: plugboard, both rotors, reflector and the inverse tables.
// Depends on enig_pkg.
module enig_scramble (
	input  enig_pkg::letter_t  letter,
	input  logic               bad,
	input  enig_pkg::pos_t     pos,
	output enig_pkg::letter_t  cipher_letter
);

	enig_pkg::letter_t idx;
	enig_pkg::letter_t t_plug;
	enig_pkg::letter_t t_fast;
	enig_pkg::letter_t t_mid;
	enig_pkg::letter_t t_refl;
	enig_pkg::letter_t t_mid_inv;
	enig_pkg::letter_t t_fast_inv;

	always_comb begin
		idx        = bad ? '0 : letter;
		t_plug     = enig_pkg::PLUG_TAB[idx];
		t_fast     = enig_pkg::FAST_FWD[enig_pkg::add_mod(t_plug, pos.fast)];
		t_mid      = enig_pkg::MID_FWD[enig_pkg::add_mod(t_fast, pos.mid)];
		t_refl     = enig_pkg::REFLECT_TAB[t_mid];
		t_mid_inv  = enig_pkg::MID_INV[t_refl];
		t_fast_inv = enig_pkg::FAST_INV[t_mid_inv];
		cipher_letter = bad ? '0 : t_fast_inv;
	end

endmodule
